/* design/tls_pkg.sv */
// Shared types and constants for the temperature log statistics unit.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package tls_pkg;

    localparam int DEF_MAX_READINGS = 1024;

    localparam int READING_W = 16;
    localparam int VAL_W     = 15;
    localparam int COUNT_W   = 11;
    localparam int INDEX_W   = 10;
    localparam int CFG_IDX_W = 2;

    localparam int QUO_W  = VAL_W;
    localparam int STEP_W = $clog2(QUO_W);

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_LIMIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 2'd3;

    localparam logic signed [READING_W-1:0] RST_NORMAL_LIMIT    = 16'sd2900;
    localparam logic signed [READING_W-1:0] RST_WARNING_LIMIT   = 16'sd4400;
    localparam logic signed [READING_W-1:0] RST_CRITICAL_LIMIT  = 16'sd5900;
    localparam logic signed [READING_W-1:0] RST_ALERT_THRESHOLD = 16'sd4500;

    localparam int NUM_BANDS = 4;
    localparam logic [1:0] BAND_NORMAL   = 2'd0;
    localparam logic [1:0] BAND_WARNING  = 2'd1;
    localparam logic [1:0] BAND_CRITICAL = 2'd2;
    localparam logic [1:0] BAND_SHUTDOWN = 2'd3;

    typedef struct packed {
        logic beat;
        logic last;
        logic div_step;
        logic load_out;
    } tls_cmd_t;

endpackage

/* design/tls_ctrl.sv */
// Controller for the temperature log statistics unit: input gating, the
// mean division sequence and the output register valid flag.
// Depends on tls_pkg.
module tls_ctrl
    import tls_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     final_reading,
    input  logic     out_stall,
    output logic     in_stall,
    output logic     out_valid,
    output tls_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT,
        ST_DIVIDE,
        ST_WRITE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_free;

    always_comb
    begin
        cmd.beat     = in_valid && (state_reg == ST_ACCEPT);
        cmd.last     = cmd.beat && final_reading;
        cmd.div_step = (state_reg == ST_DIVIDE);
        out_free     = !out_valid_reg || !out_stall;
        cmd.load_out = (state_reg == ST_WRITE) && out_free;

        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_ACCEPT:
            begin
                if (cmd.last)
                begin
                    state_next = ST_DIVIDE;
                    step_next  = '0;
                end
            end
            ST_DIVIDE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_ACCEPT);
    assign out_valid = out_valid_reg;

endmodule

/* design/tls_datapath.sv */
// Datapath for the temperature log statistics unit: limit registers,
// running statistics, result snapshot, restoring divider and output register.
// Depends on tls_pkg; driven by tls_ctrl through tls_cmd_t.
module tls_datapath
    import tls_pkg::*;
#(
    parameter int MAX_READINGS = DEF_MAX_READINGS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tls_cmd_t                    cmd,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [READING_W-1:0] cfg_data,
    input  logic signed [READING_W-1:0] reading,
    output logic [VAL_W-1:0]            lowest_reading,
    output logic [VAL_W-1:0]            highest_reading,
    output logic [VAL_W-1:0]            mean_reading,
    output logic [COUNT_W-1:0]          normal_count,
    output logic [COUNT_W-1:0]          warning_count,
    output logic [COUNT_W-1:0]          critical_count,
    output logic [COUNT_W-1:0]          shutdown_count,
    output logic [COUNT_W-1:0]          error_count,
    output logic                        any_valid,
    output logic                        alert_found,
    output logic [INDEX_W-1:0]          alert_index,
    output logic signed [READING_W-1:0] alert_value
);

    localparam int CNT_W = $clog2(MAX_READINGS + 1);
    localparam int POS_W = $clog2(MAX_READINGS);
    localparam int SUM_W = CNT_W + VAL_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_READINGS);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_READINGS - 1);

    logic signed [READING_W-1:0] normal_limit_reg;
    logic signed [READING_W-1:0] warning_limit_reg;
    logic signed [READING_W-1:0] critical_limit_reg;
    logic signed [READING_W-1:0] alert_threshold_reg;

    logic [VAL_W-1:0]            low_reg,       low_next;
    logic [VAL_W-1:0]            high_reg,      high_next;
    logic [SUM_W-1:0]            sum_reg,       sum_next;
    logic [CNT_W-1:0]            total_reg,     total_next;
    logic [CNT_W-1:0]            tally_reg      [NUM_BANDS];
    logic [CNT_W-1:0]            tally_next     [NUM_BANDS];
    logic [CNT_W-1:0]            err_reg,       err_next;
    logic [POS_W-1:0]            pos_reg,       pos_next;
    logic                        seen_reg,      seen_next;
    logic                        alert_reg,     alert_next;
    logic [POS_W-1:0]            alert_pos_reg, alert_pos_next;
    logic signed [READING_W-1:0] alert_val_reg, alert_val_next;

    logic [VAL_W-1:0]            value;
    logic [1:0]                  band_sel;

    logic [VAL_W-1:0]            hold_low_reg;
    logic [VAL_W-1:0]            hold_high_reg;
    logic [CNT_W-1:0]            hold_tally_reg [NUM_BANDS];
    logic [CNT_W-1:0]            hold_err_reg;
    logic                        hold_seen_reg;
    logic                        hold_alert_reg;
    logic [POS_W-1:0]            hold_alert_pos_reg;
    logic signed [READING_W-1:0] hold_alert_val_reg;

    logic [SUM_W-1:0]            rem_reg;
    logic [SUM_W-1:0]            dsh_reg;
    logic [QUO_W-1:0]            quo_reg;

    logic [POS_W+INDEX_W-1:0]    pos_wide;
    logic [CNT_W+COUNT_W-1:0]    cnt_wide       [NUM_BANDS];
    logic [CNT_W+COUNT_W-1:0]    err_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_limit_reg    <= RST_NORMAL_LIMIT;
            warning_limit_reg   <= RST_WARNING_LIMIT;
            critical_limit_reg  <= RST_CRITICAL_LIMIT;
            alert_threshold_reg <= RST_ALERT_THRESHOLD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NORMAL_LIMIT:    normal_limit_reg    <= cfg_data;
                REG_WARNING_LIMIT:   warning_limit_reg   <= cfg_data;
                REG_CRITICAL_LIMIT:  critical_limit_reg  <= cfg_data;
                REG_ALERT_THRESHOLD: alert_threshold_reg <= cfg_data;
                default:             normal_limit_reg    <= normal_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        value = reading[VAL_W-1:0];

        if (reading <= normal_limit_reg)
            band_sel = BAND_NORMAL;
        else if (reading <= warning_limit_reg)
            band_sel = BAND_WARNING;
        else if (reading <= critical_limit_reg)
            band_sel = BAND_CRITICAL;
        else
            band_sel = BAND_SHUTDOWN;

        alert_next     = alert_reg;
        alert_pos_next = alert_pos_reg;
        alert_val_next = alert_val_reg;
        if (!alert_reg && (reading >= alert_threshold_reg))
        begin
            alert_next     = 1'b1;
            alert_pos_next = pos_reg;
            alert_val_next = reading;
        end

        low_next   = low_reg;
        high_next  = high_reg;
        sum_next   = sum_reg;
        total_next = total_reg;
        err_next   = err_reg;
        seen_next  = seen_reg;
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            tally_next[b] = tally_reg[b];
        end

        if (reading[READING_W-1])
        begin
            if (err_reg < CNT_MAX)
                err_next = err_reg + 1'b1;
        end
        else
        begin
            seen_next = 1'b1;
            if (!seen_reg || (value < low_reg))
                low_next = value;
            if (!seen_reg || (value > high_reg))
                high_next = value;
            if (total_reg < CNT_MAX)
            begin
                sum_next   = sum_reg + {{CNT_W{1'b0}}, value};
                total_next = total_reg + 1'b1;
            end
            if (tally_reg[band_sel] < CNT_MAX)
                tally_next[band_sel] = tally_reg[band_sel] + 1'b1;
        end

        pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= '0;
            high_reg      <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            err_reg       <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            alert_reg     <= 1'b0;
            alert_pos_reg <= '0;
            alert_val_reg <= '0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                tally_reg[b] <= '0;
            end
        end
        else if (cmd.last)
        begin
            low_reg       <= '0;
            high_reg      <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            err_reg       <= '0;
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            alert_reg     <= 1'b0;
            alert_pos_reg <= '0;
            alert_val_reg <= '0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                tally_reg[b] <= '0;
            end
        end
        else if (cmd.beat)
        begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            err_reg       <= err_next;
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            alert_reg     <= alert_next;
            alert_pos_reg <= alert_pos_next;
            alert_val_reg <= alert_val_next;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                tally_reg[b] <= tally_next[b];
            end
        end
    end

    // The mean is below 2^15, so fifteen restoring steps with the divisor
    // pre-shifted by fourteen places produce the whole quotient.
    always_ff @(posedge clk)
    begin
        if (cmd.last)
        begin
            hold_low_reg       <= low_next;
            hold_high_reg      <= high_next;
            hold_err_reg       <= err_next;
            hold_seen_reg      <= seen_next;
            hold_alert_reg     <= alert_next;
            hold_alert_pos_reg <= alert_pos_next;
            hold_alert_val_reg <= alert_val_next;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                hold_tally_reg[b] <= tally_next[b];
            end
            rem_reg <= sum_next;
            dsh_reg <= {1'b0, total_next, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_comb
    begin
        pos_wide = {{INDEX_W{1'b0}}, hold_alert_pos_reg};
        err_wide = {{COUNT_W{1'b0}}, hold_err_reg};
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            cnt_wide[b] = {{COUNT_W{1'b0}}, hold_tally_reg[b]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            lowest_reading  <= hold_low_reg;
            highest_reading <= hold_high_reg;
            mean_reading    <= hold_seen_reg ? quo_reg : '0;
            normal_count    <= cnt_wide[BAND_NORMAL][COUNT_W-1:0];
            warning_count   <= cnt_wide[BAND_WARNING][COUNT_W-1:0];
            critical_count  <= cnt_wide[BAND_CRITICAL][COUNT_W-1:0];
            shutdown_count  <= cnt_wide[BAND_SHUTDOWN][COUNT_W-1:0];
            error_count     <= err_wide[COUNT_W-1:0];
            any_valid       <= hold_seen_reg;
            alert_found     <= hold_alert_reg;
            alert_index     <= pos_wide[INDEX_W-1:0];
            alert_value     <= hold_alert_val_reg;
        end
    end

endmodule

/* design/temperature_log_statistics_unit.sv */
// Top level of the temperature log statistics unit.
// Instantiates tls_ctrl and tls_datapath; depends on tls_pkg.
//
// Readings arrive on the input channel (in_valid, in_stall, reading,
// final_reading), one beat per reading, with final_reading set on the last
// beat of a log. After the last beat the input stalls while a restoring
// divider forms the truncated mean, one quotient bit per cycle, and then
// the result moves into the output register once that register is free.
// The result leaves on the output channel (out_valid, out_stall and the
// result fields) as one beat per log. While that beat is stalled the next
// log is still accepted; only the next result waits for the register, and
// the input stays stalled while it waits.
// Limits must be written via cfg_write, cfg_index and cfg_data while the
// unit is idle, which the unit does not enforce. Reset restores the default
// limits, clears all running statistics and empties the output register.
module temperature_log_statistics_unit
    import tls_pkg::*;
#(
    parameter int MAX_READINGS = DEF_MAX_READINGS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic signed [READING_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [READING_W-1:0] reading,
    input  logic                        final_reading,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [VAL_W-1:0]            lowest_reading,
    output logic [VAL_W-1:0]            highest_reading,
    output logic [VAL_W-1:0]            mean_reading,
    output logic [COUNT_W-1:0]          normal_count,
    output logic [COUNT_W-1:0]          warning_count,
    output logic [COUNT_W-1:0]          critical_count,
    output logic [COUNT_W-1:0]          shutdown_count,
    output logic [COUNT_W-1:0]          error_count,
    output logic                        any_valid,
    output logic                        alert_found,
    output logic [INDEX_W-1:0]          alert_index,
    output logic signed [READING_W-1:0] alert_value
);

    tls_cmd_t cmd;

    tls_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .final_reading (final_reading),
        .out_stall     (out_stall),
        .in_stall      (in_stall),
        .out_valid     (out_valid),
        .cmd           (cmd)
    );

    tls_datapath #(
        .MAX_READINGS (MAX_READINGS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .reading         (reading),
        .lowest_reading  (lowest_reading),
        .highest_reading (highest_reading),
        .mean_reading    (mean_reading),
        .normal_count    (normal_count),
        .warning_count   (warning_count),
        .critical_count  (critical_count),
        .shutdown_count  (shutdown_count),
        .error_count     (error_count),
        .any_valid       (any_valid),
        .alert_found     (alert_found),
        .alert_index     (alert_index),
        .alert_value     (alert_value)
    );

endmodule

/* design/tls_checker.sv */
// Port-level checks for the temperature log statistics unit, bound to the
// top level. Depends on tls_pkg and temperature_log_statistics_unit.
module tls_checker
    import tls_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        final_reading,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [VAL_W-1:0]            lowest_reading,
    input logic [VAL_W-1:0]            highest_reading,
    input logic [VAL_W-1:0]            mean_reading,
    input logic                        any_valid,
    input logic                        alert_found,
    input logic [INDEX_W-1:0]          alert_index,
    input logic signed [READING_W-1:0] alert_value
);

    // The last beat of a log starts the mean division, which blocks input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && final_reading) |=> in_stall)
        else $error("input not stalled after the last beat of a log");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(mean_reading)
            && $stable(lowest_reading) && $stable(alert_index)))
        else $error("stalled result beat changed");

    // A log with no valid reading reports zero statistics.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !any_valid) |->
            (lowest_reading == '0 && highest_reading == '0 && mean_reading == '0))
        else $error("nonzero statistics without a valid reading");

    // The mean lies between the minimum and the maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && any_valid) |->
            (lowest_reading <= mean_reading && mean_reading <= highest_reading))
        else $error("mean outside the range of readings");

    // Without an alert the alert position and value are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !alert_found) |-> (alert_index == '0 && alert_value == '0))
        else $error("alert fields set without an alert");

endmodule

bind temperature_log_statistics_unit tls_checker u_tls_checker (.*);
